// ===== sv/lcmc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcmc_pkg
// Shared constants, state encoding and controller/datapath bundles for the
// LRU cache miss counter.
// ----------------------------------------------------------------------------
package lcmc_pkg;

  // fixed field widths
  localparam int PAGE_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int CFG_W   = 5;
  localparam int MISS_W  = 32;

  // defaults for the top-level parameters
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_STAMP_BITS = 32;

  // reset value of the active entry register
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } lcmc_state_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch request, restart scan
    logic issue;   // read entry at scan index
    logic finish;  // commit update and load result
  } lcmc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_empty;  // no entry filled yet
    logic scan_last;   // scan index is the last filled entry
    logic out_free;    // result register can take a new result
  } lcmc_status_t;

endpackage : lcmc_pkg
`default_nettype wire

// ===== sv/lcmc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcmc channel interfaces
// Request, result and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface lcmc_req_if;
  logic                          valid;
  logic                          ready;
  logic [lcmc_pkg::PAGE_W-1:0]   page;
  logic                          last_request;

  modport source (output valid, output page, output last_request, input ready);
  modport sink   (input valid, input page, input last_request, output ready);
endinterface : lcmc_req_if

interface lcmc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [lcmc_pkg::SLOT_W-1:0]   slot;
  logic                          evicted;
  logic [lcmc_pkg::PAGE_W-1:0]   evicted_page;
  logic [lcmc_pkg::MISS_W-1:0]   miss_count;

  modport source (output valid, output hit, output slot, output evicted,
                  output evicted_page, output miss_count, input ready);
  modport sink   (input valid, input hit, input slot, input evicted,
                  input evicted_page, input miss_count, output ready);
endinterface : lcmc_rsp_if

interface lcmc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lcmc_pkg::CFG_W-1:0]    active_entries;

  modport source (output valid, output active_entries, input ready);
  modport sink   (input valid, input active_entries, output ready);
endinterface : lcmc_cfg_if
`default_nettype wire

// ===== sv/lcmc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcmc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lcmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : lcmc_ram
`default_nettype wire

// ===== sv/lcmc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcmc_ctrl
// Request sequencer: accept, scan filled entries, drain the read pipe,
// then commit the update and hand the result to the output register.
// ----------------------------------------------------------------------------
module lcmc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  lcmc_pkg::lcmc_status_t  status,
  output lcmc_pkg::lcmc_cmd_t     cmd
);
  import lcmc_pkg::*;

  lcmc_state_t state;
  lcmc_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = status.fill_empty ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule : lcmc_ctrl
`default_nettype wire

// ===== sv/lcmc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcmc_datapath
// Tag and stamp stores, scan logic for hit and oldest entry, sequence
// counters, configuration register and the result register.
// ----------------------------------------------------------------------------
module lcmc_datapath #(
  parameter int ENTRIES    = lcmc_pkg::DEF_ENTRIES,
  parameter int STAMP_BITS = lcmc_pkg::DEF_STAMP_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lcmc_pkg::lcmc_cmd_t             cmd,
  output lcmc_pkg::lcmc_status_t          status,
  input  logic [lcmc_pkg::PAGE_W-1:0]     page,
  input  logic                            last_request,
  input  logic                            cfg_valid,
  input  logic [lcmc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            rsp_ready,
  output logic                            rsp_valid,
  output logic                            rsp_hit,
  output logic [lcmc_pkg::SLOT_W-1:0]     rsp_slot,
  output logic                            rsp_evicted,
  output logic [lcmc_pkg::PAGE_W-1:0]     rsp_evicted_page,
  output logic [lcmc_pkg::MISS_W-1:0]     rsp_miss_count
);
  import lcmc_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WIDE_W = CNT_W + CFG_W;

  // configuration
  logic [CFG_W-1:0]      active_entries;

  // request latch
  logic [PAGE_W-1:0]     page_q;
  logic                  last_q;

  // scan pipe
  logic [IDX_W-1:0]      scan_idx;
  logic                  rd_valid;
  logic [IDX_W-1:0]      rd_idx;
  logic [PAGE_W-1:0]     tag_rd;
  logic [STAMP_BITS-1:0] stamp_rd;

  // scan results
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [STAMP_BITS-1:0] min_stamp;
  logic [IDX_W-1:0]      min_idx;
  logic [PAGE_W-1:0]     min_tag;

  // sequence state
  logic [CNT_W-1:0]      fill_count;
  logic [STAMP_BITS-1:0] request_clock;
  logic [MISS_W-1:0]     miss_total;

  // derived
  logic [WIDE_W-1:0]     act_wide;
  logic [CNT_W-1:0]      limit;
  logic [CNT_W-1:0]      scan_cnt_next;
  logic                  fill_room;
  logic                  in_limit;
  logic [IDX_W-1:0]      wr_slot;
  logic [MISS_W-1:0]     miss_next;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  // clamp the active entry count to 1..ENTRIES
  always_comb begin
    act_wide = WIDE_W'(active_entries);
    if (active_entries == '0) begin
      limit = CNT_W'(1);
    end else if (act_wide > WIDE_W'(ENTRIES)) begin
      limit = CNT_W'(ENTRIES);
    end else begin
      limit = act_wide[CNT_W-1:0];
    end
  end

  // status toward the controller
  assign scan_cnt_next     = CNT_W'(scan_idx) + CNT_W'(1);
  assign status.scan_last  = (scan_cnt_next == fill_count);
  assign status.fill_empty = (fill_count == '0);
  assign status.out_free   = !rsp_valid || rsp_ready;

  // commit decisions
  assign fill_room = (fill_count < limit);
  assign in_limit  = (CNT_W'(rd_idx) < limit);
  assign miss_next = (miss_total == '1) ? miss_total : miss_total + MISS_W'(1);
  always_comb begin
    if (hit_found) begin
      wr_slot = hit_idx;
    end else if (fill_room) begin
      wr_slot = fill_count[IDX_W-1:0];
    end else begin
      wr_slot = min_idx;
    end
  end
  assign slot_ext = (IDX_W + SLOT_W)'(wr_slot);

  // tag store
  lcmc_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (cmd.finish && !hit_found),
    .wr_addr (wr_slot),
    .wr_data (page_q),
    .rd_en   (cmd.issue),
    .rd_addr (scan_idx),
    .rd_data (tag_rd)
  );

  // use stamp store
  lcmc_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (ENTRIES)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (cmd.finish),
    .wr_addr (wr_slot),
    .wr_data (request_clock),
    .rd_en   (cmd.issue),
    .rd_addr (scan_idx),
    .rd_data (stamp_rd)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RESET;
    end else if (cfg_valid) begin
      active_entries <= cfg_data;
    end
  end

  // latch request and advance scan index
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_q   <= page;
      last_q   <= last_request;
      scan_idx <= '0;
    end else if (cmd.issue) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    rd_idx <= scan_idx;
  end

  // read pipe valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
    end
  end

  // first tag match
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found <= 1'b0;
    end else if (cmd.start) begin
      hit_found <= 1'b0;
    end else if (rd_valid && !hit_found && (tag_rd == page_q)) begin
      hit_found <= 1'b1;
      hit_idx   <= rd_idx;
    end
  end

  // oldest stamp among active entries, lowest index wins ties
  always_ff @(posedge clk) begin
    if (rd_valid && in_limit && ((rd_idx == '0) || (stamp_rd < min_stamp))) begin
      min_stamp <= stamp_rd;
      min_idx   <= rd_idx;
      min_tag   <= tag_rd;
    end
  end

  // sequence counters: update on commit, clear after the last request
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      request_clock <= '0;
      miss_total    <= '0;
    end else if (cmd.finish) begin
      if (last_q) begin
        fill_count    <= '0;
        request_clock <= '0;
        miss_total    <= '0;
      end else begin
        request_clock <= request_clock + STAMP_BITS'(1);
        if (!hit_found) begin
          miss_total <= miss_next;
          if (fill_room) begin
            fill_count <= fill_count + CNT_W'(1);
          end
        end
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_hit          <= hit_found;
      rsp_slot         <= slot_ext[SLOT_W-1:0];
      rsp_evicted      <= !hit_found && !fill_room;
      rsp_evicted_page <= (!hit_found && !fill_room) ? min_tag : '0;
      rsp_miss_count   <= hit_found ? miss_total : miss_next;
    end
  end

endmodule : lcmc_datapath
`default_nettype wire

// ===== sv/lru_cache_miss_counter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_cache_miss_counter_unit
// Fully associative LRU cache model that reports hit, slot, eviction and a
// saturating miss count for each page request.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  req     | in  | valid / ready | page, last_request
//  rsp     | out | valid / ready | hit, slot, evicted, evicted_page,
//          |     |               | miss_count
//  cfg     | in  | valid / ready | active_entries (always ready)
//
//  A request is accepted, reads the stamp and tag RAMs once per filled entry,
//  drains the registered read and commits; while the cache is empty it goes
//  from accept straight to commit. The scan runs through the one read port
//  of each entry RAM, and a new request is accepted only after a commit.
//  Reset clears the sequence counters and sets active_entries to 16; the
//  entry stores are not cleared. A stalled result holds in the output
//  register; the next request is accepted meanwhile and waits at commit.
// ----------------------------------------------------------------------------
module lru_cache_miss_counter_unit #(
  parameter int ENTRIES    = lcmc_pkg::DEF_ENTRIES,
  parameter int STAMP_BITS = lcmc_pkg::DEF_STAMP_BITS
) (
  input  logic        clk,
  input  logic        rst,
  lcmc_req_if.sink    req,
  lcmc_rsp_if.source  rsp,
  lcmc_cfg_if.sink    cfg
);
  import lcmc_pkg::*;

  lcmc_cmd_t    cmd;
  lcmc_status_t status;
  logic         req_ready;

  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;

  // sequencer
  lcmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // stores, scan and result register
  lcmc_datapath #(
    .ENTRIES    (ENTRIES),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .page             (req.page),
    .last_request     (req.last_request),
    .cfg_valid        (cfg.valid),
    .cfg_data         (cfg.active_entries),
    .rsp_ready        (rsp.ready),
    .rsp_valid        (rsp.valid),
    .rsp_hit          (rsp.hit),
    .rsp_slot         (rsp.slot),
    .rsp_evicted      (rsp.evicted),
    .rsp_evicted_page (rsp.evicted_page),
    .rsp_miss_count   (rsp.miss_count)
  );

endmodule : lru_cache_miss_counter_unit
`default_nettype wire

// ===== tb/lru_cache_miss_counter_unit_test.sv =====
// ----------------------------------------------------------------------------
// lru_cache_miss_counter_unit_test
// Self-checking bench for the LRU cache miss counter. Page requests go in
// over a valid/ready channel with random gaps. A behavioral LRU predictor
// queues one expected result per accepted request, and every result taken
// from the block is compared field by field against it. The active entry
// register is rewritten between phases, both between and in the middle of
// sequences, and the result side is held off for a long stretch once.
// ----------------------------------------------------------------------------
module lru_cache_miss_counter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcmc_pkg::*;

  localparam int NUM_ENTRIES = DEF_ENTRIES;
  localparam int STAMP_W     = DEF_STAMP_BITS;
  localparam int IDLE_PCT    = 34;
  localparam int RANDOM_PHASES     = 12;
  localparam int ITEMS_PER_PHASE   = 125;
  localparam int HOLD_OFF_CYCLES   = 300;

  typedef struct packed {
    bit                hit;
    bit [SLOT_W-1:0]   slot;
    bit                evicted;
    bit [PAGE_W-1:0]   evicted_page;
    bit [MISS_W-1:0]   miss_count;
  } lookup_result_t;

  logic clk;
  logic rst;

  lcmc_req_if req_ch ();
  lcmc_rsp_if rsp_ch ();
  lcmc_cfg_if cfg_ch ();

  lru_cache_miss_counter_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // predictor state
  bit [CFG_W-1:0]   active_setting;
  bit [PAGE_W-1:0]  resident_page [NUM_ENTRIES];
  bit [STAMP_W-1:0] last_use [NUM_ENTRIES];
  int               filled;
  bit [STAMP_W-1:0] use_clock;
  bit [MISS_W-1:0]  miss_total;

  lookup_result_t pending_results[$];

  // traffic shaping
  bit steady_traffic;
  int stall_left;

  // random sequence generator state
  bit [PAGE_W-1:0] page_pool[$];
  int              seq_left;

  // run statistics
  int mismatch_count;
  int requests_sent;
  int results_checked;
  int hits_seen;
  int evictions_seen;
  int sequences_closed;
  int config_writes;

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // effective entry count for the current register value
  function automatic int entry_limit();
    if (active_setting == 0) return 1;
    if (active_setting > NUM_ENTRIES) return NUM_ENTRIES;
    return int'(active_setting);
  endfunction

  // clear the per-sequence counters; entries are left as they are
  function automatic void clear_sequence();
    filled = 0;
    use_clock = '0;
    miss_total = '0;
  endfunction

  // look one page up in the LRU model and return what the block must report
  function automatic lookup_result_t lru_access(input bit [PAGE_W-1:0] page, input bit last);
    lookup_result_t r;
    int lim;
    int victim;
    bit found;
    r = '0;
    lim = entry_limit();
    found = 1'b0;
    for (int i = 0; i < filled; i++) begin
      if (!found && resident_page[i] == page) begin
        found = 1'b1;
        r.slot = SLOT_W'(i);
        last_use[i] = use_clock;
      end
    end
    r.hit = found;
    if (!found) begin
      if (miss_total != '1) miss_total++;
      if (filled < lim) begin
        victim = filled;
        filled++;
      end else begin
        victim = 0;
        for (int i = 1; i < lim; i++)
          if (last_use[i] < last_use[victim]) victim = i;
        r.evicted = 1'b1;
        r.evicted_page = resident_page[victim];
      end
      r.slot = SLOT_W'(victim);
      resident_page[victim] = page;
      last_use[victim] = use_clock;
    end
    use_clock++;
    r.miss_count = miss_total;
    if (last) begin
      clear_sequence();
      sequences_closed++;
    end
    if (r.hit) hits_seen++;
    if (r.evicted) evictions_seen++;
    return r;
  endfunction

  // result side: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp_ch.ready = 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready = steady_traffic || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.hit = rsp_ch.hit;
      got.slot = rsp_ch.slot;
      got.evicted = rsp_ch.evicted;
      got.evicted_page = rsp_ch.evicted_page;
      got.miss_count = rsp_ch.miss_count;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: hit=%0b slot=%0d evicted=%0b page=%h misses=%0d",
                   got.hit, got.slot, got.evicted, got.evicted_page, got.miss_count);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch on result %0d:", results_checked);
            $display("  expected hit=%0b slot=%0d evicted=%0b page=%h misses=%0d",
                     want.hit, want.slot, want.evicted, want.evicted_page, want.miss_count);
            $display("  actual   hit=%0b slot=%0d evicted=%0b page=%h misses=%0d",
                     got.hit, got.slot, got.evicted, got.evicted_page, got.miss_count);
          end
        end
      end
    end
  end

  // offer one request, with random gaps ahead of it, and predict its result
  task automatic send_request(input bit [PAGE_W-1:0] page, input bit last);
    @(negedge clk);
    while (!steady_traffic && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.page = page;
    req_ch.last_request = last;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(lru_access(page, last));
    requests_sent++;
  endtask

  // drop the request valid and wait for every outstanding result
  task automatic settle_outstanding();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write the active entry register while the block is idle
  task automatic write_active_entries(input bit [CFG_W-1:0] value);
    settle_outstanding();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.active_entries = value;
    do @(posedge clk); while (!cfg_ch.ready);
    active_setting = value;
    config_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // draw a page, biased toward all-zero and all-one identifiers now and then
  function automatic bit [PAGE_W-1:0] random_page();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // start a new sequence with a fresh working set
  function automatic void open_sequence();
    int pool_size;
    page_pool.delete();
    seq_left = ($urandom_range(4) == 0) ? $urandom_range(1, 6) : $urandom_range(10, 80);
    if ($urandom_range(3) == 0) pool_size = $urandom_range(1, 3);
    else pool_size = entry_limit() + $urandom_range(0, 4);
    for (int i = 0; i < pool_size; i++) page_pool.push_back(random_page());
  endfunction

  // mostly pages from the working set, some fresh ones as noise
  task automatic send_random_requests(input int count);
    bit [PAGE_W-1:0] page;
    for (int n = 0; n < count; n++) begin
      if (seq_left == 0) open_sequence();
      if ($urandom_range(7) == 0) page = random_page();
      else page = page_pool[$urandom_range(page_pool.size() - 1)];
      seq_left--;
      send_request(page, seq_left == 0);
    end
  endtask

  // extreme pages, a hit and a sequence end at the reset register value
  task automatic test_sequence_basics();
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hA5A5_5A5A, 1'b1);
  endtask

  // a zero register acts as one entry
  task automatic test_entry_count_limits();
    write_active_entries(5'd0);
    send_request(32'h0000_1000, 1'b0);
    send_request(32'h0000_2000, 1'b0);
    send_request(32'h0000_2000, 1'b0);
    send_request(32'h0000_1000, 1'b1);
  endtask

  // shrink and grow the active set in the middle of an open sequence
  task automatic test_live_resize();
    write_active_entries(5'd3);
    send_request(32'h1111_0001, 1'b0);
    send_request(32'h1111_0002, 1'b0);
    send_request(32'h1111_0003, 1'b0);
    send_request(32'h1111_0001, 1'b0);
    send_request(32'h1111_0004, 1'b0);
    write_active_entries(5'd1);
    send_request(32'h1111_0003, 1'b0);
    send_request(32'h1111_0005, 1'b0);
    write_active_entries(5'd20);
    send_request(32'h1111_0006, 1'b0);
    send_request(32'h1111_0006, 1'b1);
  endtask

  // hold the result side off while requests keep coming
  task automatic test_stalled_results();
    write_active_entries(5'd16);
    @(posedge clk);
    stall_left = HOLD_OFF_CYCLES;
    send_random_requests(60);
  endtask

  // no gaps on either side
  task automatic test_back_to_back();
    write_active_entries(5'd8);
    steady_traffic = 1'b1;
    send_random_requests(150);
    settle_outstanding();
    steady_traffic = 1'b0;
  endtask

  // random phases over several register values, extremes first
  task automatic test_random_traffic();
    bit [CFG_W-1:0] setting;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: setting = 5'd16;
        1: setting = 5'd1;
        2: setting = 5'd0;
        3: setting = 5'd31;
        4: setting = 5'd2;
        5: setting = 5'd17;
        default: setting = $urandom_range(31);
      endcase
      write_active_entries(setting);
      send_random_requests(ITEMS_PER_PHASE);
    end
  endtask

  // hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.page = '0;
    req_ch.last_request = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.active_entries = '0;
    rsp_ch.ready = 1'b0;
    steady_traffic = 1'b0;
    stall_left = 0;
    seq_left = 0;
    mismatch_count = 0;
    requests_sent = 0;
    results_checked = 0;
    hits_seen = 0;
    evictions_seen = 0;
    sequences_closed = 0;
    config_writes = 0;
    active_setting = ACTIVE_RESET;
    clear_sequence();

    // hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_sequence_basics();
    test_entry_count_limits();
    test_live_resize();
    test_stalled_results();
    test_back_to_back();
    test_random_traffic();

    // drain, then watch a while for stray results
    settle_outstanding();
    repeat (2 * (NUM_ENTRIES + 3)) @(posedge clk);

    $display("%0d requests in %0d closed sequences, %0d register writes",
             requests_sent, sequences_closed, config_writes);
    $display("%0d results checked: %0d hits, %0d evictions, %0d mismatches",
             results_checked, hits_seen, evictions_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : lru_cache_miss_counter_unit_test

// ===== files.f =====
sv/lcmc_pkg.sv
sv/lcmc_if.sv
sv/lcmc_ram.sv
sv/lcmc_ctrl.sv
sv/lcmc_datapath.sv
sv/lru_cache_miss_counter_unit.sv
tb/lru_cache_miss_counter_unit_test.sv
